>>> rtl/core/grt_pkg.sv
// ----------------------------------------------------------------------------
// grt_pkg
// Shared types, constants and helpers for the glyph text renderer.
// ----------------------------------------------------------------------------
package grt_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int MAX_ROWS    = 32;
    localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WORD_W      = 16;
    // Search position: table_length (13 bits) plus one record step (16 bits + 5)
    localparam int POS_W       = 17;
    localparam int CFG_DATA_W  = 13;
    localparam int REC_HDR     = 5;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_START   = 2'd1,
        OP_DRAW    = 2'd2,
        OP_MEASURE = 2'd3
    } op_t;

    typedef enum logic {
        REG_CELL_WIDTH   = 1'b0,
        REG_TABLE_LENGTH = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CODE,
        ST_HOP,
        ST_WIDTH,
        ST_HEIGHT,
        ST_XOFF,
        ST_YOFF,
        ST_ROW
    } grt_state_t;

    typedef struct packed {
        op_t                opcode;
        logic [11:0]        table_address;
        logic [15:0]        table_word;
        logic [7:0]         char_code;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
    } grt_in_t;

    typedef struct packed {
        logic               row_valid;
        logic               glyph_found;
        logic signed [15:0] row_x;
        logic signed [15:0] row_y;
        logic [15:0]        row_bits;
        logic [4:0]         row_width;
        logic signed [15:0] pen_x;
        logic               last;
    } grt_out_t;

    // floor(v/3) for 8-bit v: multiply by 171/512
    function automatic logic [6:0] div3(input logic [7:0] v);
        logic [15:0] prod;
        begin
            prod = 16'(v) * 16'd171;
            return prod[15:9];
        end
    endfunction

    // Left-aligned pixel mask for a width of 0 to 16
    function automatic logic [15:0] row_mask(input logic [4:0] w);
        begin
            if (w == 5'd0)
            begin
                return 16'h0000;
            end
            return 16'hFFFF << (5'd16 - w);
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        begin
            if (v > 18'sd32767)
            begin
                return 16'sh7FFF;
            end
            if (v < -18'sd32768)
            begin
                return 16'sh8000;
            end
            return v[15:0];
        end
    endfunction

endpackage

>>> rtl/core/grt_store.sv
// ----------------------------------------------------------------------------
// grt_store
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module grt_store #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/glyph_text_renderer.sv
// ----------------------------------------------------------------------------
// glyph_text_renderer
// Bitmap font character generator: walks glyph records held in a RAM,
// advances the pen and emits one result per bitmap row.
// ----------------------------------------------------------------------------
//  channel   | signals                              | transaction
//  ----------+--------------------------------------+--------------------------
//  command   | start, busy, item                    | start && !busy at clk
//  result    | result_strobe, result                | every strobe cycle
//  config    | cfg_we, cfg_index, cfg_data          | cfg_we at clk
//
//  Load and start-line commands complete in the accept cycle (busy stays low).
//  Draw/measure: each record skipped in the search passes SEARCH, CODE, HOP;
//  the matching header is read in SEARCH, CODE, WIDTH, HEIGHT, XOFF, YOFF,
//  then one row per cycle; results come from the output register. Not found
//  ends in SEARCH. One RAM read port (one access per cycle) sets the pace.
//  Reset is asynchronous; the glyph RAM is not cleared. Results cannot stall.
// ----------------------------------------------------------------------------
module glyph_text_renderer
    import grt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  grt_in_t               item,
    output logic                  result_strobe,
    output grt_out_t              result,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    grt_state_t state_reg, state_next;

    logic [7:0]              cell_width_reg;
    logic [CFG_DATA_W-1:0]   table_length_reg;
    logic signed [15:0]      pen_reg;
    logic signed [15:0]      base_reg;
    logic signed [15:0]      rowx_reg;
    logic signed [17:0]      ytop_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [7:0]              code_reg;
    op_t                     op_reg;
    logic [4:0]              width_reg;
    logic                    wide_reg;
    logic [15:0]             height_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [ROW_W-1:0]        nrows_m1_reg;
    logic                    oob_reg;
    grt_out_t                result_reg, result_next;
    logic                    strobe_reg, strobe_next;

    logic                    accept;
    logic                    mem_we;
    logic                    rd_en;
    logic [POS_W-1:0]        rd_addr;
    logic [WORD_W-1:0]       mem_q;
    logic [WORD_W-1:0]       rd_data;
    logic                    code_hit;
    logic                    single_out;
    logic                    row_last;
    logic signed [17:0]      pen_sum;
    logic signed [17:0]      ysum;
    logic [15:0]             row_word;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign mem_we = accept && (item.opcode == OP_LOAD)
                    && ({5'd0, item.table_address} < POS_W'(TABLE_DEPTH));

    // Writes happen only in idle and reads only while busy, so no overlap
    grt_store #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WORD_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (ADDR_W'(item.table_address)),
        .wr_data (item.table_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr[ADDR_W-1:0]),
        .rd_data (mem_q)
    );

    // Addresses past the store read as zero
    assign rd_data    = oob_reg ? '0 : mem_q;
    assign code_hit   = (rd_data[7:0] == code_reg);
    assign single_out = (op_reg == OP_MEASURE) || wide_reg || (height_reg == 16'd0);
    assign row_last   = (row_reg == nrows_m1_reg);

    assign pen_sum = $signed({{2{pen_reg[15]}}, pen_reg})
                   + $signed({10'd0, cell_width_reg})
                   + $signed({11'd0, div3(cell_width_reg)})
                   - $signed({{2{rd_data[15]}}, rd_data});
    assign ysum    = ytop_reg + $signed({{(18-ROW_W){1'b0}}, row_reg});
    assign row_word = (width_reg < 5'd9) ? {rd_data[7:0], 8'h00} : rd_data;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.opcode == OP_DRAW || item.opcode == OP_MEASURE))
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                state_next = (pos_reg < POS_W'(table_length_reg)) ? ST_CODE : ST_IDLE;
            end
            ST_CODE:   state_next = code_hit ? ST_WIDTH : ST_HOP;
            ST_HOP:    state_next = ST_SEARCH;
            ST_WIDTH:  state_next = ST_HEIGHT;
            ST_HEIGHT: state_next = ST_XOFF;
            ST_XOFF:   state_next = ST_YOFF;
            ST_YOFF:   state_next = single_out ? ST_IDLE : ST_ROW;
            ST_ROW:    state_next = row_last ? ST_IDLE : ST_ROW;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Read port control and result formation
    always_comb
    begin
        rd_en       = 1'b0;
        rd_addr     = pos_reg;
        strobe_next = 1'b0;
        result_next = '0;
        unique case (state_reg)
            ST_SEARCH:
            begin
                rd_en = 1'b1;
                if (!(pos_reg < POS_W'(table_length_reg)))
                begin
                    // search exhausted: not found, pen untouched
                    strobe_next       = 1'b1;
                    result_next.pen_x = pen_reg;
                    result_next.last  = 1'b1;
                end
            end
            ST_CODE:
            begin
                rd_en   = 1'b1;
                rd_addr = code_hit ? pos_reg + POS_W'(1) : pos_reg + POS_W'(2);
            end
            ST_WIDTH:
            begin
                rd_en   = 1'b1;
                rd_addr = pos_reg + POS_W'(2);
            end
            ST_HEIGHT:
            begin
                rd_en   = 1'b1;
                rd_addr = pos_reg + POS_W'(3);
            end
            ST_XOFF:
            begin
                rd_en   = 1'b1;
                rd_addr = pos_reg + POS_W'(4);
            end
            ST_YOFF:
            begin
                rd_en   = 1'b1;
                rd_addr = pos_reg + POS_W'(REC_HDR);
                if (single_out)
                begin
                    strobe_next             = 1'b1;
                    result_next.glyph_found = 1'b1;
                    result_next.pen_x       = pen_reg;
                    result_next.last        = 1'b1;
                end
            end
            ST_ROW:
            begin
                rd_en   = 1'b1;
                rd_addr = pos_reg + POS_W'(REC_HDR + 1) + POS_W'(row_reg);
                strobe_next             = 1'b1;
                result_next.row_valid   = 1'b1;
                result_next.glyph_found = 1'b1;
                result_next.row_x       = rowx_reg;
                result_next.row_y       = sat16(ysum);
                result_next.row_bits    = row_word & row_mask(width_reg);
                result_next.row_width   = width_reg;
                result_next.pen_x       = pen_reg;
                result_next.last        = row_last;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            strobe_reg       <= 1'b0;
            cell_width_reg   <= 8'd8;
            table_length_reg <= '0;
            pen_reg          <= '0;
            base_reg         <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CELL_WIDTH:   cell_width_reg   <= cfg_data[7:0];
                    REG_TABLE_LENGTH: table_length_reg <= cfg_data;
                    default:          cell_width_reg   <= cell_width_reg;
                endcase
            end
            if (accept && item.opcode == OP_START)
            begin
                pen_reg  <= item.start_x;
                base_reg <= item.start_y;
            end
            if (state_reg == ST_XOFF)
            begin
                pen_reg <= sat16(pen_sum);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        oob_reg    <= (rd_addr >= POS_W'(TABLE_DEPTH));
        if (accept)
        begin
            pos_reg  <= '0;
            code_reg <= item.char_code;
            op_reg   <= item.opcode;
        end
        case (state_reg)
            ST_HOP:
            begin
                // advance to the next record
                pos_reg <= pos_reg + POS_W'(rd_data) + POS_W'(REC_HDR);
            end
            ST_WIDTH:
            begin
                width_reg <= rd_data[4:0];
                wide_reg  <= (rd_data > 16'd16);
            end
            ST_HEIGHT:
            begin
                height_reg   <= rd_data;
                nrows_m1_reg <= (rd_data < 16'(MAX_ROWS)) ? ROW_W'(rd_data - 16'd1)
                                                          : ROW_W'(MAX_ROWS - 1);
            end
            ST_XOFF:
            begin
                rowx_reg <= pen_reg;
            end
            ST_YOFF:
            begin
                ytop_reg <= $signed({{2{base_reg[15]}}, base_reg})
                          - $signed({{2{rd_data[15]}}, rd_data})
                          - $signed({2'b00, height_reg});
                row_reg  <= '0;
            end
            ST_ROW:
            begin
                row_reg <= row_reg + ROW_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // Rows of one glyph leave on consecutive cycles
    a_rows_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last |=> result_strobe)
        else $error("row burst broken before last");

    // All rows of one glyph share the same x
    a_row_x_steady: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last |=> result.row_x == $past(result.row_x))
        else $error("row x changed within a glyph");

    // A result only follows busy work
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result without a command in progress");

endmodule
